// ===== hw/rtl/rqi_pkg.sv =====
// Shared constants, types and arithmetic helpers for the ray/quad intersection block.
package rqi_pkg;

  localparam int COORD_BITS  = 21;
  localparam int COORD_FRAC  = 10;
  localparam int DIST_BITS   = 32;
  localparam int DIST_FRAC   = 16;
  localparam int EPS_FRAC    = 30;
  localparam int EPS_BITS    = 40;
  localparam int CORNER_BITS = 3 * COORD_BITS;
  localparam int CFG_W       = (CORNER_BITS > EPS_BITS) ? CORNER_BITS : EPS_BITS;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_B = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_C = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_D = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_DET_EPS  = CFG_IDX_W'(4);

  localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(107374);

  localparam int EDGE_W   = COORD_BITS + 1;
  localparam int PP_W     = 2 * EDGE_W;
  localparam int XP_W     = PP_W + 1;
  localparam int LO_W     = XP_W / 2;
  localparam int HI_W     = XP_W - LO_W;
  localparam int PH_W     = EDGE_W + HI_W;
  localparam int PL_W     = EDGE_W + LO_W + 1;
  localparam int DOT_W    = EDGE_W + XP_W + 2;
  localparam int NUM_W    = DOT_W + DIST_FRAC;
  localparam int DIVCMP_W = DOT_W + DIST_BITS;
  localparam int EPSCMP_W = DOT_W + EPS_BITS + 3 * COORD_FRAC + EPS_FRAC;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;
  typedef logic signed [PP_W-1:0]       pp_t;
  typedef logic signed [XP_W-1:0]       xp_t;
  typedef logic signed [PH_W-1:0]       ph_t;
  typedef logic signed [PL_W-1:0]       pl_t;
  typedef logic signed [DOT_W-1:0]      dot_t;

  typedef struct packed { edge_t x; edge_t y; edge_t z; } evec_t;
  typedef struct packed { xp_t x; xp_t y; xp_t z; } xvec_t;
  typedef struct packed { pp_t xa; pp_t xb; pp_t ya; pp_t yb; pp_t za; pp_t zb; } xpp_t;
  typedef struct packed { ph_t hx; ph_t hy; ph_t hz; pl_t lx; pl_t ly; pl_t lz; } dpp_t;
  typedef struct packed { dot_t x; dot_t y; dot_t z; } dprod_t;

  typedef struct packed {
    logic [CORNER_BITS-1:0] corner_a;
    logic [CORNER_BITS-1:0] corner_b;
    logic [CORNER_BITS-1:0] corner_c;
    logic [CORNER_BITS-1:0] corner_d;
    logic [EPS_BITS-1:0]    det_eps;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic                 prior_valid;
    logic [DIST_BITS-1:0] prior_distance;
    logic [DOT_W-1:0]     nt;
    logic [DOT_W-1:0]     mag;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic nempty;
    job_t job;
  } qstat_t;

  function automatic edge_t ext_coord(input logic [COORD_BITS-1:0] c);
    return EDGE_W'(signed'(c));
  endfunction

  function automatic evec_t unpack_corner(input logic [CORNER_BITS-1:0] p);
    evec_t v;
    v.x = ext_coord(p[COORD_BITS-1:0]);
    v.y = ext_coord(p[2*COORD_BITS-1:COORD_BITS]);
    v.z = ext_coord(p[3*COORD_BITS-1:2*COORD_BITS]);
    return v;
  endfunction

  function automatic evec_t vsub(input evec_t a, input evec_t b);
    evec_t v;
    v.x = a.x - b.x;
    v.y = a.y - b.y;
    v.z = a.z - b.z;
    return v;
  endfunction

  function automatic pp_t mul_pp(input edge_t a, input edge_t b);
    pp_t r;
    r = PP_W'(a) * PP_W'(b);
    return r;
  endfunction

  function automatic xpp_t cross_pp(input evec_t a, input evec_t b);
    xpp_t r;
    r.xa = mul_pp(a.y, b.z);
    r.xb = mul_pp(a.z, b.y);
    r.ya = mul_pp(a.z, b.x);
    r.yb = mul_pp(a.x, b.z);
    r.za = mul_pp(a.x, b.y);
    r.zb = mul_pp(a.y, b.x);
    return r;
  endfunction

  function automatic xvec_t cross_fin(input xpp_t p);
    xvec_t r;
    r.x = XP_W'(p.xa) - XP_W'(p.xb);
    r.y = XP_W'(p.ya) - XP_W'(p.yb);
    r.z = XP_W'(p.za) - XP_W'(p.zb);
    return r;
  endfunction

  function automatic ph_t mul_hi(input edge_t a, input xp_t b);
    ph_t r;
    r = PH_W'(a) * PH_W'($signed(b[XP_W-1:LO_W]));
    return r;
  endfunction

  function automatic pl_t mul_lo(input edge_t a, input xp_t b);
    pl_t r;
    r = PL_W'(a) * PL_W'($signed({1'b0, b[LO_W-1:0]}));
    return r;
  endfunction

  function automatic dpp_t dot_pp(input evec_t a, input xvec_t b);
    dpp_t r;
    r.hx = mul_hi(a.x, b.x);
    r.hy = mul_hi(a.y, b.y);
    r.hz = mul_hi(a.z, b.z);
    r.lx = mul_lo(a.x, b.x);
    r.ly = mul_lo(a.y, b.y);
    r.lz = mul_lo(a.z, b.z);
    return r;
  endfunction

  function automatic dprod_t dot_prod(input dpp_t p);
    dprod_t r;
    r.x = (DOT_W'(p.hx) <<< LO_W) + DOT_W'(p.lx);
    r.y = (DOT_W'(p.hy) <<< LO_W) + DOT_W'(p.ly);
    r.z = (DOT_W'(p.hz) <<< LO_W) + DOT_W'(p.lz);
    return r;
  endfunction

  function automatic dot_t dot_sum(input dprod_t p);
    return p.x + p.y + p.z;
  endfunction

  function automatic logic det_ok(input logic [DOT_W-1:0] mag,
                                  input logic [EPS_BITS-1:0] eps);
    logic [EPSCMP_W-1:0] lhs;
    logic [EPSCMP_W-1:0] rhs;
    lhs = EPSCMP_W'(mag) << EPS_FRAC;
    rhs = EPSCMP_W'(eps) << (3 * COORD_FRAC);
    return (mag != '0) && (lhs >= rhs);
  endfunction

endpackage

// ===== hw/rtl/rqi_in_if.sv =====
// Ray input channel: valid/ready handshake with ray and prior-hit payload.
interface rqi_in_if;
  import rqi_pkg::*;

  logic                 valid;
  logic                 ready;
  coord_t               origin_x;
  coord_t               origin_y;
  coord_t               origin_z;
  coord_t               dir_x;
  coord_t               dir_y;
  coord_t               dir_z;
  logic                 prior_valid;
  logic [DIST_BITS-1:0] prior_distance;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  prior_valid, prior_distance, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  prior_valid, prior_distance, output ready);
endinterface

// ===== hw/rtl/rqi_out_if.sv =====
// Result channel: valid/ready handshake with hit, accept and distance payload.
interface rqi_out_if;
  import rqi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 accept;
  logic [DIST_BITS-1:0] hit_distance;

  modport source (output valid, hit, accept, hit_distance, input ready);
  modport sink   (input valid, hit, accept, hit_distance, output ready);
endinterface

// ===== hw/rtl/ray_quad_intersection.sv =====
// Ray/quad intersection top level: config registers, front, queue and back.
// Throughput: one ray per cycle; the front admits rays while it holds queue credit
// (16 entries), so an output stall fills the queue before the input stalls.
// The back is a 32-stage restoring divider, one quotient bit per stage.
// Reset (synchronous, rst_n low) clears all valid and credit state; corners reset
// to 0 and det_epsilon to 107374.
module ray_quad_intersection (
  input  logic                            clk,
  input  logic                            rst_n,
  rqi_in_if.sink                          in_ch,
  rqi_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rqi_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rqi_pkg::CFG_W-1:0]       cfg_data
);
  import rqi_pkg::*;

  cfg_t   cfg_r;
  push_t  push;
  qstat_t head;
  logic   pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.corner_a <= '0;
      cfg_r.corner_b <= '0;
      cfg_r.corner_c <= '0;
      cfg_r.corner_d <= '0;
      cfg_r.det_eps  <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CORNER_A: cfg_r.corner_a <= cfg_data[CORNER_BITS-1:0];
        CFG_CORNER_B: cfg_r.corner_b <= cfg_data[CORNER_BITS-1:0];
        CFG_CORNER_C: cfg_r.corner_c <= cfg_data[CORNER_BITS-1:0];
        CFG_CORNER_D: cfg_r.corner_d <= cfg_data[CORNER_BITS-1:0];
        CFG_DET_EPS:  cfg_r.det_eps  <= cfg_data[EPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  rqi_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg_r),
    .pop   (pop),
    .push  (push)
  );

  rqi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head)
  );

  rqi_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== hw/rtl/rqi_front.sv =====
// Front pipeline: determinants, barycentric numerators and hit classification.
module rqi_front (
  input  logic          clk,
  input  logic          rst_n,
  rqi_in_if.sink        in_ch,
  input  rqi_pkg::cfg_t cfg,
  input  logic          pop,
  output rqi_pkg::push_t push
);
  import rqi_pkg::*;

  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              acc;

  evec_t v00, v11, e01, e03, e23, e21;

  logic [7:0] vld_r;

  evec_t                o0_r, d0_r;
  logic                 pv_r  [0:7];
  logic [DIST_BITS-1:0] pd_r  [0:7];

  evec_t t1_r, t01_r, d1_r;
  xpp_t  pp_p_r, pp_p0_r, pp_q_r, pp_q0_r;

  evec_t t2_r, t02_r, d2_r;
  xvec_t p_r, p0_r, q_r, q0_r;

  dpp_t  dp_det_r, dp_na_r, dp_nb_r, dp_nt_r, dp_det0_r, dp_a0_r, dp_b0_r;
  dprod_t pr_det_r, pr_na_r, pr_nb_r, pr_nt_r, pr_det0_r, pr_a0_r, pr_b0_r;
  dot_t  det_r, na_r, nb_r, nt_r, det0_r, a0_r, b0_r;

  logic [DOT_W-1:0] mag6_r, mag06_r;
  dot_t             na6_r, nb6_r, nt6_r;
  logic             sec_sign_ok6_r;

  logic             hit_nxt;
  logic [DOT_W:0]   nab_sum;
  evec_t            t1_nxt, t01_nxt;

  logic             hit7_r;
  logic [DOT_W-1:0] nt7_r, mag7_r;

  logic             neg, neg0;
  logic [DOT_W-1:0] mag_nxt, mag0_nxt;
  dot_t             na_nxt, nb_nxt, nt_nxt;
  logic             a0_bad, b0_bad;

  assign v00 = unpack_corner(cfg.corner_a);
  assign v11 = unpack_corner(cfg.corner_c);
  assign e01 = vsub(unpack_corner(cfg.corner_b), v00);
  assign e03 = vsub(unpack_corner(cfg.corner_d), v00);
  assign e23 = vsub(unpack_corner(cfg.corner_d), v11);
  assign e21 = vsub(unpack_corner(cfg.corner_b), v11);

  assign in_ch.ready = (cnt_r < QCNT_W'(QUEUE_DEPTH));
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!acc && pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= {vld_r[6:0], acc};
    end
  end

  // Stage 0: capture the beat; prior fields ride along.
  always_ff @(posedge clk) begin
    if (acc) begin
      o0_r.x   <= ext_coord(in_ch.origin_x);
      o0_r.y   <= ext_coord(in_ch.origin_y);
      o0_r.z   <= ext_coord(in_ch.origin_z);
      d0_r.x   <= ext_coord(in_ch.dir_x);
      d0_r.y   <= ext_coord(in_ch.dir_y);
      d0_r.z   <= ext_coord(in_ch.dir_z);
      pv_r[0]  <= in_ch.prior_valid;
      pd_r[0]  <= in_ch.prior_distance;
    end
    for (int s = 1; s < 8; s++) begin
      pv_r[s] <= pv_r[s-1];
      pd_r[s] <= pd_r[s-1];
    end
  end

  // Stage 1: cross-product partial terms.
  assign t1_nxt  = vsub(o0_r, v00);
  assign t01_nxt = vsub(o0_r, v11);

  always_ff @(posedge clk) begin
    t1_r    <= t1_nxt;
    t01_r   <= t01_nxt;
    d1_r    <= d0_r;
    pp_p_r  <= cross_pp(d0_r, e03);
    pp_p0_r <= cross_pp(d0_r, e21);
    pp_q_r  <= cross_pp(t1_nxt, e01);
    pp_q0_r <= cross_pp(t01_nxt, e23);
  end

  // Stage 2: cross products.
  always_ff @(posedge clk) begin
    t2_r  <= t1_r;
    t02_r <= t01_r;
    d2_r  <= d1_r;
    p_r   <= cross_fin(pp_p_r);
    p0_r  <= cross_fin(pp_p0_r);
    q_r   <= cross_fin(pp_q_r);
    q0_r  <= cross_fin(pp_q0_r);
  end

  // Stages 3-5: split dot products, recombine, sum.
  always_ff @(posedge clk) begin
    dp_det_r  <= dot_pp(e01, p_r);
    dp_na_r   <= dot_pp(t2_r, p_r);
    dp_nb_r   <= dot_pp(d2_r, q_r);
    dp_nt_r   <= dot_pp(e03, q_r);
    dp_det0_r <= dot_pp(e23, p0_r);
    dp_a0_r   <= dot_pp(t02_r, p0_r);
    dp_b0_r   <= dot_pp(d2_r, q0_r);

    pr_det_r  <= dot_prod(dp_det_r);
    pr_na_r   <= dot_prod(dp_na_r);
    pr_nb_r   <= dot_prod(dp_nb_r);
    pr_nt_r   <= dot_prod(dp_nt_r);
    pr_det0_r <= dot_prod(dp_det0_r);
    pr_a0_r   <= dot_prod(dp_a0_r);
    pr_b0_r   <= dot_prod(dp_b0_r);

    det_r  <= dot_sum(pr_det_r);
    na_r   <= dot_sum(pr_na_r);
    nb_r   <= dot_sum(pr_nb_r);
    nt_r   <= dot_sum(pr_nt_r);
    det0_r <= dot_sum(pr_det0_r);
    a0_r   <= dot_sum(pr_a0_r);
    b0_r   <= dot_sum(pr_b0_r);
  end

  // Stage 6: orient numerators by determinant sign.
  always_comb begin
    neg      = det_r[DOT_W-1];
    neg0     = det0_r[DOT_W-1];
    mag_nxt  = neg ? DOT_W'(-det_r) : DOT_W'(det_r);
    mag0_nxt = neg0 ? DOT_W'(-det0_r) : DOT_W'(det0_r);
    na_nxt   = neg ? -na_r : na_r;
    nb_nxt   = neg ? -nb_r : nb_r;
    nt_nxt   = neg ? -nt_r : nt_r;
    a0_bad   = neg0 ? (a0_r > 0) : a0_r[DOT_W-1];
    b0_bad   = neg0 ? (b0_r > 0) : b0_r[DOT_W-1];
  end

  always_ff @(posedge clk) begin
    mag6_r         <= mag_nxt;
    mag06_r        <= mag0_nxt;
    na6_r          <= na_nxt;
    nb6_r          <= nb_nxt;
    nt6_r          <= nt_nxt;
    sec_sign_ok6_r <= !a0_bad && !b0_bad;
  end

  // Stage 7: classify.
  always_comb begin
    nab_sum = (DOT_W+1)'(unsigned'(na6_r)) + (DOT_W+1)'(unsigned'(nb6_r));
    hit_nxt = det_ok(mag6_r, cfg.det_eps)
           && !na6_r[DOT_W-1] && (unsigned'(na6_r) <= mag6_r)
           && !nb6_r[DOT_W-1] && (unsigned'(nb6_r) <= mag6_r)
           && ((nab_sum <= (DOT_W+1)'(mag6_r))
               || (det_ok(mag06_r, cfg.det_eps) && sec_sign_ok6_r))
           && !nt6_r[DOT_W-1] && (nt6_r != '0);
  end

  always_ff @(posedge clk) begin
    hit7_r <= hit_nxt;
    nt7_r  <= unsigned'(nt6_r);
    mag7_r <= mag6_r;
  end

  assign push.valid              = vld_r[7];
  assign push.job.hit            = hit7_r;
  assign push.job.prior_valid    = pv_r[7];
  assign push.job.prior_distance = pd_r[7];
  assign push.job.nt             = nt7_r;
  assign push.job.mag            = mag7_r;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("front credit count exceeds queue depth");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QCNT_W'(QUEUE_DEPTH)) && !pop |=> !acc || cnt_r == QCNT_W'(QUEUE_DEPTH))
    else $error("front credit count moved while full");

endmodule

// ===== hw/rtl/rqi_queue.sv =====
// Job queue between the classifying front and the dividing back.
module rqi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  rqi_pkg::push_t  push,
  input  logic            pop,
  output rqi_pkg::qstat_t head
);
  import rqi_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  assign head.nempty = (cnt_r != '0);
  assign head.job    = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (cnt_r != QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue pop while empty");

endmodule

// ===== hw/rtl/rqi_back.sv =====
// Back pipeline: restoring distance divider, saturation and accept compare.
module rqi_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rqi_pkg::qstat_t head,
  output logic            pop,
  rqi_out_if.source       out_ch
);
  import rqi_pkg::*;

  typedef struct packed {
    logic                 hit;
    logic                 pv;
    logic [DIST_BITS-1:0] pd;
    logic                 sat;
    logic [DOT_W-1:0]     mag;
    logic [NUM_W-1:0]     rem;
    logic [DIST_BITS-1:0] quo;
  } dstage_t;

  logic                 en;
  logic [DIST_BITS:0]   dvld_r;
  dstage_t              dst_r [0:DIST_BITS];
  dstage_t              init;
  dstage_t              last;
  logic [DIST_BITS-1:0] dist_val;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_accept_r;
  logic [DIST_BITS-1:0] out_dist_r;

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && head.nempty;

  always_comb begin
    init.hit = head.job.hit;
    init.pv  = head.job.prior_valid;
    init.pd  = head.job.prior_distance;
    init.mag = head.job.mag;
    init.rem = {head.job.nt, {DIST_FRAC{1'b0}}};
    init.quo = '0;
    init.sat = (DIVCMP_W'({head.job.nt, {DIST_FRAC{1'b0}}})
                >= (DIVCMP_W'(head.job.mag) << DIST_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst_r[0] <= init;
    end
  end

  for (genvar k = 0; k < DIST_BITS; k++) begin : g_div
    localparam int SH = DIST_BITS - 1 - k;
    logic [DIVCMP_W-1:0] rem_ext;
    logic [DIVCMP_W-1:0] dvs;
    logic                ge;
    dstage_t             stg_nxt;

    always_comb begin
      rem_ext = DIVCMP_W'(dst_r[k].rem);
      dvs     = DIVCMP_W'(dst_r[k].mag) << SH;
      ge      = rem_ext >= dvs;
      stg_nxt = dst_r[k];
      if (ge) begin
        stg_nxt.rem     = NUM_W'(rem_ext - dvs);
        stg_nxt.quo[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dst_r[k+1] <= stg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dvld_r      <= {dvld_r[DIST_BITS-1:0], pop};
      out_valid_r <= dvld_r[DIST_BITS];
    end
  end

  assign last = dst_r[DIST_BITS];

  always_comb begin
    if (!last.hit) begin
      dist_val = '0;
    end else if (last.sat) begin
      dist_val = '1;
    end else begin
      dist_val = last.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r    <= last.hit;
      out_accept_r <= last.hit && (!last.pv || (dist_val < last.pd));
      out_dist_r   <= dist_val;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.accept       = out_accept_r;
  assign out_ch.hit_distance = out_dist_r;

  a_miss_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_dist_r == '0)
    else $error("miss beat carries a nonzero distance");

  a_accept_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_accept_r |-> out_hit_r)
    else $error("accept without hit");

endmodule
